// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files of the command frame parser.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/cfpl_pkg.sv -----
// Package of the command frame parser: sizes, codes, reset values and shared types.
// Depends on nothing; imported by every other RTL file.
`default_nettype none

package cfpl_pkg;

    localparam int FRAME_BYTES   = 12;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 4;
    localparam int PAYLOAD_W     = 64;
    localparam int COUNT_W       = 4;
    localparam int PAY_IDX_W     = 3;
    localparam int TIMER_WIDTH   = 16;
    localparam int TIMEOUT_W     = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;
    localparam logic [7:0]           START_RESET   = 8'h42;
    localparam logic [7:0]           END_RESET     = 8'h24;

    localparam logic [COUNT_W-1:0] POS_ID        = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_PAY_FIRST = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_PAY_LAST  = COUNT_W'(FRAME_BYTES - 3);
    localparam logic [COUNT_W-1:0] POS_END       = COUNT_W'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_DROP    = 3'd1,
        ST_OK      = 3'd2,
        ST_BAD_END = 3'd3,
        ST_BAD_SUM = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_START   = 2'd1,
        REG_END     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        PS_HUNT,
        PS_COLLECT
    } parser_state_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [7:0]           start_marker;
        logic [7:0]           end_marker;
    } cfg_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           cmd_code;
        logic [PAYLOAD_W-1:0] payload;
        logic                 frame_ok;
    } parse_res_t;

    typedef struct packed {
        logic link_up;
        logic motor_halt;
    } link_res_t;

endpackage

`default_nettype wire

// ----- design/cfpl_channels.sv -----
// Channel interfaces of the command frame parser: item, result and configuration write.
// Depends on cfpl_pkg for field widths.
`default_nettype none

interface cfpl_item_if
    import cfpl_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, action, byte_value, input ready);
    modport sink   (input valid, action, byte_value, output ready);
endinterface

interface cfpl_result_if
    import cfpl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [7:0]           cmd_code;
    logic [PAYLOAD_W-1:0] payload;
    logic                 link_up;
    logic                 motor_halt;

    modport source (output valid, status, cmd_code, payload, link_up, motor_halt,
                    input ready);
    modport sink   (input valid, status, cmd_code, payload, link_up, motor_halt,
                    output ready);
endinterface

interface cfpl_cfg_if
    import cfpl_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/command_frame_parser_with_link_timeout.sv -----
// Top level of the command frame parser with link watchdog.
// Depends on cfpl_pkg, cfpl_channels, cfpl_cfg_regs, cfpl_frame_parser,
// cfpl_link_timer and assert_macros.svh.
//
//   channel | direction | carries
//   --------+-----------+-------------------------------------------------
//   cfg     | in        | register index and write data
//   item    | in        | action (byte or tick) and byte_value
//   result  | out       | status, cmd_code, payload, link_up, motor_halt
//
// Every item is captured in the input register, processed by the parser and the
// watchdog when it moves on to the result register, and its result lands in the result
// register. One item can be accepted in every cycle while the result is being taken.
// Reset is asynchronous and active low; it restores the register defaults and
// puts the parser in its hunting state with the link down.
// A stalled result holds the result register; the input register then fills
// and item.ready drops until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module command_frame_parser_with_link_timeout
    import cfpl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfpl_cfg_if.sink    cfg,
    cfpl_item_if.sink   item,
    cfpl_result_if.source result
);

    cfg_t       regs;
    parse_res_t parse_res;
    link_res_t  link_res;

    // Input register: one item waiting to be processed.
    logic       in_valid_reg, in_valid_next;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    // Result register.
    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg;
    logic [7:0]           res_id_reg;
    logic [PAYLOAD_W-1:0] res_pay_reg;
    logic                 res_link_reg;
    logic                 res_stop_reg;

    logic advance;
    logic item_xfer;

    // The held item moves on whenever the result register is empty or is
    // being drained in this cycle.
    assign advance    = in_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign item_xfer  = item.valid && item.ready;

    cfpl_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cfpl_frame_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_en      (advance && !in_action_reg),
        .byte_value   (in_byte_reg),
        .start_marker (regs.start_marker),
        .end_marker   (regs.end_marker),
        .res          (parse_res)
    );

    cfpl_link_timer u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (advance && in_action_reg),
        .frame_ok   (parse_res.frame_ok),
        .timeout_ms (regs.timeout_ms),
        .res        (link_res)
    );

    always_comb
    begin
        if (item_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_action_reg <= item.action;
            in_byte_reg   <= item.byte_value;
        end
        if (advance)
        begin
            res_status_reg <= parse_res.status;
            res_id_reg     <= parse_res.cmd_code;
            res_pay_reg    <= parse_res.payload;
            res_link_reg   <= link_res.link_up;
            res_stop_reg   <= link_res.motor_halt;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.status     = res_status_reg;
    assign result.cmd_code   = res_id_reg;
    assign result.payload    = res_pay_reg;
    assign result.link_up    = res_link_reg;
    assign result.motor_halt = res_stop_reg;

    // A motor stop always comes with the link going down.
    `ASSERT_IMPL(a_stop_means_down, clk, rst_n, res_valid_reg && res_stop_reg, !res_link_reg)
    // An accepted frame always leaves the link up.
    `ASSERT_IMPL(a_ok_means_up, clk, rst_n, res_valid_reg && res_status_reg == ST_OK, res_link_reg)
    // Stop is only raised by ticks, which never report a byte status.
    `ASSERT_IMPL(a_stop_no_status, clk, rst_n, res_valid_reg && res_stop_reg, res_status_reg == ST_NONE)
    // A held item that cannot move on is never lost.
    `ASSERT_NEXT(a_item_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

// ----- design/cfpl_cfg_regs.sv -----
// Configuration register file: timeout and the two frame markers.
// Depends on cfpl_pkg and cfpl_channels.
`default_nettype none

module cfpl_cfg_regs
    import cfpl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfpl_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_TIMEOUT: regs_next.timeout_ms   = cfg.data[TIMEOUT_W-1:0];
                REG_START:   regs_next.start_marker = cfg.data[7:0];
                REG_END:     regs_next.end_marker   = cfg.data[7:0];
                default:     regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout_ms   <= TIMEOUT_RESET;
            regs_reg.start_marker <= START_RESET;
            regs_reg.end_marker   <= END_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

// ----- design/cfpl_frame_parser.sv -----
// Frame parser: hunts for the start marker, collects a frame and checks end byte and XOR.
// Depends on cfpl_pkg.
`default_nettype none

module cfpl_frame_parser
    import cfpl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] byte_value,
    input  wire logic [7:0] start_marker,
    input  wire logic [7:0] end_marker,
    output parse_res_t      res
);

    parser_state_t        state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]           xor_reg, xor_next;
    logic [7:0]           id_reg, id_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [PAY_IDX_W-1:0] pay_idx;

    assign pay_idx = PAY_IDX_W'(count_reg - POS_PAY_FIRST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (byte_en)
        begin
            unique case (state_reg)
                PS_HUNT:    if (byte_value == start_marker) state_next = PS_COLLECT;
                PS_COLLECT: if (count_reg >= POS_END) state_next = PS_HUNT;
                default:    state_next = PS_HUNT;
            endcase
        end
    end

    // Datapath and results
    always_comb
    begin
        count_next = count_reg;
        xor_next   = xor_reg;
        id_next    = id_reg;
        pay_next   = pay_reg;
        res        = '{status: ST_NONE, cmd_code: 8'd0, payload: '0, frame_ok: 1'b0};
        if (byte_en)
        begin
            unique case (state_reg)
                PS_HUNT:
                begin
                    if (byte_value == start_marker)
                    begin
                        count_next = COUNT_W'(1);
                        xor_next   = byte_value;
                        id_next    = 8'd0;
                        pay_next   = '0;
                    end
                    else
                    begin
                        res.status = ST_DROP;
                    end
                end
                PS_COLLECT:
                begin
                    if (count_reg < POS_END)
                    begin
                        xor_next   = xor_reg ^ byte_value;
                        count_next = count_reg + COUNT_W'(1);
                        if (count_reg == POS_ID)
                            id_next = byte_value;
                        else if (count_reg >= POS_PAY_FIRST && count_reg <= POS_PAY_LAST)
                            pay_next[8*pay_idx +: 8] = byte_value;
                    end
                    else
                    begin
                        // The end byte is checked before the checksum.
                        if (byte_value != end_marker)
                            res.status = ST_BAD_END;
                        else if (xor_reg != 8'd0)
                            res.status = ST_BAD_SUM;
                        else
                        begin
                            res.status   = ST_OK;
                            res.cmd_code = id_reg;
                            res.payload  = pay_reg;
                            res.frame_ok = 1'b1;
                        end
                        count_next = '0;
                        xor_next   = 8'd0;
                        id_next    = 8'd0;
                        pay_next   = '0;
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_HUNT;
            count_reg <= '0;
            xor_reg   <= 8'd0;
            id_reg    <= 8'd0;
            pay_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            id_reg    <= id_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cfpl_link_timer.sv -----
// Link watchdog: saturating tick counter, link flag and motor stop on timeout.
// Depends on cfpl_pkg.
`default_nettype none

module cfpl_link_timer
    import cfpl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tick,
    input  wire logic                 frame_ok,
    input  wire logic [TIMEOUT_W-1:0] timeout_ms,
    output link_res_t                 res
);

    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                   link_reg, link_next;
    logic [TIMER_WIDTH-1:0] elapsed_inc;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg
                                             : elapsed_reg + TIMER_WIDTH'(1);

    always_comb
    begin
        elapsed_next   = elapsed_reg;
        link_next      = link_reg;
        res.motor_halt = 1'b0;
        if (frame_ok)
        begin
            elapsed_next = '0;
            link_next    = 1'b1;
        end
        else if (tick)
        begin
            elapsed_next = elapsed_inc;
            if (32'(elapsed_inc) > 32'(timeout_ms))
            begin
                link_next      = 1'b0;
                res.motor_halt = 1'b1;
            end
        end
        res.link_up = link_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            link_reg    <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            link_reg    <= link_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/command_frame_parser_with_link_timeout_tb.sv -----
// Self-checking testbench of the command frame parser with link watchdog: directed rows,
// then random frames, noise and tick bursts under several register settings and stalls.
// Depends on cfpl_pkg, the cfpl channel interfaces and the command_frame_parser_with_link_timeout RTL.
module command_frame_parser_with_link_timeout_tb;
    import cfpl_pkg::*;

    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Each item is captured, then processed, then registered.
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX  = '1;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Frame positions: start, command id, payload bytes, checksum, end.
    localparam int POS_CMD      = 1;
    localparam int POS_PAY      = 2;
    localparam int POS_CHECKSUM = FRAME_BYTES - 2;
    localparam int POS_LAST     = FRAME_BYTES - 1;

    typedef struct packed {
        status_t              status;
        logic [7:0]           cmd_code;
        logic [PAYLOAD_W-1:0] payload;
        logic                 link_up;
        logic                 motor_halt;
    } outcome_t;

    // One row of the directed table. When typed is set, the outcome written in the
    // row is what the result must be; otherwise the parser model decides.
    typedef struct packed {
        logic       act;
        logic [7:0] val;
        logic       typed;
        outcome_t   want;
    } stim_row_t;

    typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_BAD_BOTH} frame_kind_t;

    // A whole frame, byte i in bits [8*i +: 8].
    typedef logic [FRAME_BYTES*8-1:0] frame_buf_t;

    localparam outcome_t NO_OUTCOME = '{ST_NONE, 8'h00, 64'h0, 1'b0, 1'b0};

    logic clk = 1'b0;
    logic rst_n;

    cfpl_cfg_if    cfg_ch ();
    cfpl_item_if   item_ch ();
    cfpl_result_if res_ch ();

    command_frame_parser_with_link_timeout dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block: register copies and parser/watchdog state, updated at
    // every accepted transfer so the outcome queue always reflects the DUT's view.
    logic [TIMEOUT_W-1:0]   m_timeout    = TIMEOUT_RESET;
    logic [7:0]             m_start      = START_RESET;
    logic [7:0]             m_end        = END_RESET;
    logic                   m_collecting = 1'b0;
    logic [COUNT_W-1:0]     m_count      = '0;
    logic [7:0]             m_xor        = '0;
    logic [7:0]             m_cmd        = '0;
    logic [PAYLOAD_W-1:0]   m_payload    = '0;
    logic [TIMER_WIDTH-1:0] m_elapsed    = '0;
    logic                   m_link       = 1'b0;

    outcome_t outcomes_due[$];

    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    int       items_sent     = 0;
    int       send_gap_pct   = 0;
    int       recv_stall_pct = 0;

    // Side band from the item driver to the transfer watcher for typed table rows.
    logic     typed_pending = 1'b0;
    outcome_t typed_want    = NO_OUTCOME;

    // Advances the shadow parser and watchdog by one item and returns its result.
    function automatic outcome_t parse_and_time(input logic act, input logic [7:0] b);
        outcome_t o;
        int       sh;
        o = NO_OUTCOME;
        if (act == ACT_BYTE)
        begin
            if (!m_collecting)
            begin
                // Hunting: anything but the start marker is dropped.
                if (b != m_start)
                    o.status = ST_DROP;
                else
                begin
                    m_collecting = 1'b1;
                    m_count      = COUNT_W'(1);
                    m_xor        = b;
                    m_cmd        = '0;
                    m_payload    = '0;
                end
            end
            else if (m_count < POS_LAST)
            begin
                m_xor = m_xor ^ b;
                if (m_count == POS_CMD)
                    m_cmd = b;
                else if (m_count < POS_CHECKSUM)
                begin
                    sh = (int'(m_count) - POS_PAY) * 8;
                    m_payload[sh +: 8] = b;
                end
                m_count = m_count + 1'b1;
            end
            else
            begin
                // The end byte is judged before the checksum.
                if (b != m_end)
                    o.status = ST_BAD_END;
                else if (m_xor != 8'h00)
                    o.status = ST_BAD_SUM;
                else
                begin
                    o.status   = ST_OK;
                    o.cmd_code = m_cmd;
                    o.payload  = m_payload;
                    m_link     = 1'b1;
                    m_elapsed  = '0;
                end
                m_collecting = 1'b0;
                m_count      = '0;
                m_xor        = '0;
                m_cmd        = '0;
                m_payload    = '0;
            end
        end
        else
        begin
            // Ticks leave any frame in progress alone; the counter saturates.
            if (m_elapsed != TIMER_MAX)
                m_elapsed = m_elapsed + 1'b1;
            if (m_elapsed > m_timeout)
            begin
                m_link       = 1'b0;
                o.motor_halt = 1'b1;
            end
        end
        o.link_up = m_link;
        return o;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Watches all three channels at the rising edge. Register writes update the
    // shadow registers, item transfers queue their outcome, result transfers are
    // checked against the oldest queued outcome. A long stretch without any
    // transfer means the block has hung.
    always @(posedge clk)
    begin : watch_transfers
        outcome_t want;
        outcome_t calc;
        logic     moved;
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                case (cfg_ch.index)
                    REG_TIMEOUT: m_timeout = cfg_ch.data[TIMEOUT_W-1:0];
                    REG_START:   m_start   = cfg_ch.data[7:0];
                    REG_END:     m_end     = cfg_ch.data[7:0];
                    default:     ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
            begin
                moved = 1'b1;
                calc  = parse_and_time(item_ch.action, item_ch.byte_value);
                outcomes_due.push_back(typed_pending ? typed_want : calc);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (outcomes_due.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: status %0d",
                           res_ch.status);
                    mismatch_count++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    compare_field("status", 64'(want.status), 64'(res_ch.status));
                    compare_field("cmd_code", 64'(want.cmd_code), 64'(res_ch.cmd_code));
                    compare_field("payload", want.payload, res_ch.payload);
                    compare_field("link_up", 64'(want.link_up), 64'(res_ch.link_up));
                    compare_field("motor_halt", 64'(want.motor_halt),
                                  64'(res_ch.motor_halt));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // The receiver stalls at random; ready is redrawn at every falling edge.
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Offers one item, with random gaps before it, and returns at the falling edge
    // after its transfer. valid stays high so the next item follows back to back.
    task automatic send_item(input logic act, input logic [7:0] b, input logic typed,
                             input outcome_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.byte_value <= b;
        typed_pending      <= typed;
        typed_want         <= want;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_BYTE, b, 1'b0, NO_OUTCOME);
    endtask

    // The byte lane carries junk on ticks; the block must ignore it.
    task automatic send_tick();
        send_item(ACT_TICK, 8'($urandom), 1'b0, NO_OUTCOME);
    endtask

    // The sender holds off until every outstanding result has been taken.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Rewrites all registers while the block is idle. The 8-bit markers get junk
    // in the upper data bits, which the block must discard.
    task automatic set_regs(input logic [15:0] timeout, input logic [7:0] start_b,
                            input logic [7:0] end_b, input logic poke_unused);
        drain();
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_START, {8'($urandom), start_b});
        write_reg(REG_END, {8'($urandom), end_b});
        if (poke_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Builds a frame under the current markers, optionally spoiling the checksum,
    // the end byte or both.
    function automatic frame_buf_t build_frame(input logic [7:0] cmd,
                                               input logic [PAYLOAD_W-1:0] pay,
                                               input frame_kind_t kind);
        frame_buf_t f;
        logic [7:0] sum;
        f = '0;
        f[0 +: 8]             = m_start;
        f[POS_CMD*8 +: 8]     = cmd;
        f[POS_PAY*8 +: PAYLOAD_W] = pay;
        sum = m_start ^ cmd;
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            sum = sum ^ pay[k*8 +: 8];
        if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH)
            sum = sum ^ 8'($urandom_range(1, 255));
        f[POS_CHECKSUM*8 +: 8] = sum;
        f[POS_LAST*8 +: 8]     = m_end;
        if (kind == FR_BAD_END || kind == FR_BAD_BOTH)
            f[POS_LAST*8 +: 8] = m_end ^ 8'($urandom_range(1, 255));
        return f;
    endfunction

    // Sends bytes first..last of a frame, with ticks slipped in between at random.
    task automatic send_frame_bytes(input frame_buf_t f, input int first, input int last,
                                    input int tick_pct);
        for (int i = first; i <= last; i++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_tick();
            send_byte(f[i*8 +: 8]);
        end
    endtask

    task automatic random_frame();
        int          pick;
        frame_kind_t kind;
        pick = $urandom_range(99);
        kind = (pick < 70) ? FR_GOOD : (pick < 82) ? FR_BAD_SUM :
               (pick < 94) ? FR_BAD_END : FR_BAD_BOTH;
        send_frame_bytes(build_frame(8'($urandom), {$urandom, $urandom}, kind),
                         0, POS_LAST, 10);
    endtask

    // Pushes junk bytes until the shadow parser is back to hunting, so the next
    // frame starts aligned.
    task automatic close_open_frame();
        while (m_collecting)
            send_byte(8'($urandom));
    endtask

    // Random traffic: mostly well-formed frames with random content, some broken
    // ones, bursts of noise that may open a stray frame, tick bursts (now and then
    // long enough to expire the link) and occasional full pauses of the sender.
    task automatic run_random(input int count);
        int first_sent;
        int pick;
        int burst;
        first_sent = items_sent;
        while (items_sent - first_sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                random_frame();
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(99) < 20) ? m_start : 8'($urandom));
            end
            else if (pick < 97)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(99) < 8 && m_timeout < 300)
                    burst = int'(m_timeout) + 2;
                repeat (burst)
                    send_tick();
            end
            else
                drain();
        end
    endtask

    // Directed rows after reset (timeout 250, start 0x42, end 0x24). The good frame
    // carries command 0xFF and walking-one payload bytes, with a tick in the middle
    // of it; the bad frame fails both its end byte and its checksum and must be
    // reported as a bad end.
    stim_row_t directed_rows [29] = '{
        '{ACT_BYTE, 8'h00, 1'b1, '{ST_DROP, 8'h00, 64'h0, 1'b0, 1'b0}},
        '{ACT_BYTE, 8'hFF, 1'b1, '{ST_DROP, 8'h00, 64'h0, 1'b0, 1'b0}},
        '{ACT_TICK, 8'h00, 1'b1, '{ST_NONE, 8'h00, 64'h0, 1'b0, 1'b0}},
        '{ACT_BYTE, 8'h42, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'hFF, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h01, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h02, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h04, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h08, 1'b0, NO_OUTCOME},
        '{ACT_TICK, 8'hA5, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h10, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h20, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h40, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h80, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h42, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h24, 1'b1, '{ST_OK, 8'hFF, 64'h8040201008040201, 1'b1, 1'b0}},
        '{ACT_BYTE, 8'h42, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b0, NO_OUTCOME},
        '{ACT_BYTE, 8'h00, 1'b1, '{ST_BAD_END, 8'h00, 64'h0, 1'b1, 1'b0}},
        '{ACT_TICK, 8'hFF, 1'b1, '{ST_NONE, 8'h00, 64'h0, 1'b1, 1'b0}}
    };

    initial
    begin
        frame_buf_t f;

        // Every input of the block but the receiver's ready is known from time zero; that ready
        // is set at the first falling edge, well inside reset.
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        item_ch.valid      = 1'b0;
        item_ch.action     = ACT_BYTE;
        item_ch.byte_value = '0;

        // The sender gaps lightly while the receiver stalls heavily.
        send_gap_pct   = 24;
        recv_stall_pct = 58;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].want);

        // Reset register values; one deliberate pause of the sender midway.
        run_random(50);
        drain();
        run_random(50);

        // Shortest real timeout and markers at the byte extremes.
        set_regs(16'd1, 8'hFF, 8'h00, 1'b1);
        run_random(100);

        // Now the receiver gaps lightly and the sender heavily.
        send_gap_pct   = 58;
        recv_stall_pct = 24;

        // Open a frame, swap both markers and a zero timeout under it, and close
        // it with the new end marker: only the new end marker counts.
        close_open_frame();
        f = build_frame(8'($urandom), {$urandom, $urandom}, FR_GOOD);
        send_frame_bytes(f, 0, 4, 0);
        set_regs(16'd0, 8'h00, 8'hFF, 1'b0);
        f[POS_LAST*8 +: 8] = m_end;
        send_frame_bytes(f, 5, POS_LAST, 10);
        run_random(100);

        set_regs(16'd5, 8'($urandom), 8'($urandom), 1'b1);
        run_random(100);

        // No idling from here on.
        send_gap_pct   = 0;
        recv_stall_pct = 0;

        // Largest timeout: the link can never expire.
        set_regs(16'hFFFF, START_RESET, END_RESET, 1'b0);
        run_random(90);

        set_regs(16'($urandom_range(1, 40)), 8'($urandom), 8'($urandom), 1'b1);
        run_random(90);

        // A timeout at the counter's top value never expires.
        set_regs(TIMER_MAX, START_RESET, END_RESET, 1'b0);
        repeat (5)
            send_tick();
        close_open_frame();
        send_frame_bytes(build_frame(8'($urandom), {$urandom, $urandom}, FR_GOOD),
                         0, POS_LAST, 0);
        send_tick();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/cfpl_pkg.sv
design/cfpl_channels.sv
design/cfpl_cfg_regs.sv
design/cfpl_frame_parser.sv
design/cfpl_link_timer.sv
design/command_frame_parser_with_link_timeout.sv
tb/command_frame_parser_with_link_timeout_tb.sv
